@@ rtl/c8_pkg.sv @@
// shared types, codes and constants for the chip-8 instruction step core
`default_nettype none
package c8_pkg;

  localparam int MEM_DEPTH   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;

  localparam logic [11:0] PC_RESET = 12'h200;

  // item modes
  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_EXEC = 3'd1;
  localparam logic [2:0] MODE_TICK = 3'd2;
  localparam logic [2:0] MODE_KEY  = 3'd3;
  localparam logic [2:0] MODE_ROW  = 3'd4;
  localparam logic [2:0] MODE_BYTE = 3'd5;

  // top nibble groups
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  // alu sub-codes
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [7:0] KK_SKP    = 8'h9E;
  localparam logic [7:0] KK_SKNP   = 8'hA1;
  localparam logic [7:0] KK_GET_DT = 8'h07;
  localparam logic [7:0] KK_WAIT   = 8'h0A;
  localparam logic [7:0] KK_SET_DT = 8'h15;
  localparam logic [7:0] KK_SET_ST = 8'h18;
  localparam logic [7:0] KK_ADD_I  = 8'h1E;
  localparam logic [7:0] KK_FONT   = 8'h29;
  localparam logic [7:0] KK_BCD    = 8'h33;
  localparam logic [7:0] KK_STORE  = 8'h55;
  localparam logic [7:0] KK_LOAD   = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] address;
    logic [7:0]  data;
    logic [3:0]  key_index;
    logic        key_pressed;
    logic [7:0]  random_byte;
  } c8_in_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] opcode_done;
    logic [15:0] index_value;
    logic [7:0]  delay_value;
    logic        sound_on;
    logic        unknown_opcode;
    logic        waiting_key;
    logic [63:0] read_data;
  } c8_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIMPLE, ST_RDBYTE, ST_FETCH_HI, ST_FETCH_LO, ST_FETCH_END,
    ST_RD_Y, ST_EXEC, ST_DRAW_ADDR, ST_DRAW_ROW, ST_BCD, ST_STORE,
    ST_LOAD_ADDR, ST_LOAD_WR, ST_SETVF, ST_DONE
  } c8_state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CAPTURE, CMD_SIMPLE, CMD_RDBYTE, CMD_FETCH_HI, CMD_FETCH_LO,
    CMD_FETCH_END, CMD_RD_Y, CMD_EXEC, CMD_DRAW_ADDR, CMD_DRAW_ROW, CMD_BCD,
    CMD_STORE, CMD_LOAD_ADDR, CMD_LOAD_WR, CMD_SETVF, CMD_OUT
  } c8_cmd_t;

  typedef enum logic [2:0] {
    PH_DONE, PH_VF, PH_DRAW, PH_BCD, PH_STORE, PH_LOAD
  } c8_phase_t;

  typedef struct packed {
    logic      is_exec;
    logic      is_byte;
    c8_phase_t phase;
    logic      last;
  } c8_stat_t;

endpackage
`default_nettype wire

@@ rtl/c8_ctrl.sv @@
// sequencer for the chip-8 core: item handshake, micro-steps, result register valid
`default_nettype none
module c8_ctrl import c8_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  c8_stat_t stat,
  output c8_cmd_t  cmd
);

  c8_state_t state, state_next;
  logic      out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == CMD_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_CAPTURE;
          state_next = ST_SIMPLE;
        end
      end
      ST_SIMPLE: begin
        cmd = CMD_SIMPLE;
        if (stat.is_exec) begin
          state_next = ST_FETCH_HI;
        end else if (stat.is_byte) begin
          state_next = ST_RDBYTE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RDBYTE: begin
        cmd        = CMD_RDBYTE;
        state_next = ST_DONE;
      end
      ST_FETCH_HI: begin
        cmd        = CMD_FETCH_HI;
        state_next = ST_FETCH_LO;
      end
      ST_FETCH_LO: begin
        cmd        = CMD_FETCH_LO;
        state_next = ST_FETCH_END;
      end
      ST_FETCH_END: begin
        cmd        = CMD_FETCH_END;
        state_next = ST_RD_Y;
      end
      ST_RD_Y: begin
        cmd        = CMD_RD_Y;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd = CMD_EXEC;
        case (stat.phase)
          PH_VF:    state_next = ST_SETVF;
          PH_DRAW:  state_next = ST_DRAW_ADDR;
          PH_BCD:   state_next = ST_BCD;
          PH_STORE: state_next = ST_STORE;
          PH_LOAD:  state_next = ST_LOAD_ADDR;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_DRAW_ADDR: begin
        cmd        = CMD_DRAW_ADDR;
        state_next = ST_DRAW_ROW;
      end
      ST_DRAW_ROW: begin
        cmd        = CMD_DRAW_ROW;
        state_next = stat.last ? ST_SETVF : ST_DRAW_ADDR;
      end
      ST_BCD: begin
        cmd        = CMD_BCD;
        state_next = stat.last ? ST_DONE : ST_BCD;
      end
      ST_STORE: begin
        cmd        = CMD_STORE;
        state_next = stat.last ? ST_DONE : ST_STORE;
      end
      ST_LOAD_ADDR: begin
        cmd        = CMD_LOAD_ADDR;
        state_next = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd        = CMD_LOAD_WR;
        state_next = stat.last ? ST_DONE : ST_LOAD_ADDR;
      end
      ST_SETVF: begin
        cmd        = CMD_SETVF;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd        = CMD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/c8_dp.sv @@
// chip-8 datapath: memory, registers, stack, timers, keys, frame buffer, result register
`default_nettype none
module c8_dp import c8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [11:0] cfg_data,
  input  c8_in_t      in_data,
  input  c8_cmd_t     cmd,
  output c8_stat_t    stat,
  output c8_out_t     out_data
);

  // architectural state
  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  rf [16];
  logic [11:0] stk [STACK_DEPTH];
  logic [63:0] rows [SCREEN_H];
  logic [11:0] pc;
  logic [15:0] ireg;
  logic [3:0]  sp;
  logic [7:0]  dt;
  logic [7:0]  st;
  logic [15:0] keys;

  // per-item working registers
  c8_in_t      item;
  logic [15:0] op;
  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [63:0] rd;
  logic        unk;
  logic        wt;
  logic        hit;
  logic [3:0]  cnt;
  logic [3:0]  wb2_idx;
  logic [7:0]  wb2_val;
  logic [7:0]  mem_rdata;

  // decode
  logic [3:0]  grp, x, n;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2, pc4, pc_exec;
  logic        skip, rf_we, unk_n, wt_n;
  logic [3:0]  rf_widx, wb2_idx_n, rf_raddr, penc;
  logic [7:0]  rf_wval, wb2_val_n, rf_rdata;
  logic [8:0]  sum;
  c8_phase_t   phase;

  // memory port
  logic [11:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wd;

  // sprite and bcd helpers
  logic [127:0] spr_dbl;
  logic [63:0]  spr_mask;
  logic [4:0]   row_idx;
  logic [63:0]  row_val;
  logic         hit_n;
  logic [1:0]   bcd_h;
  logic [7:0]   bcd_r;
  logic [14:0]  bcd_prod;
  logic [3:0]   bcd_t;
  logic [7:0]   bcd_o;
  logic [7:0]   bcd_digit;

  assign grp = op[15:12];
  assign x   = op[11:8];
  assign n   = op[3:0];
  assign kk  = op[7:0];
  assign nnn = op[11:0];
  assign pc2 = pc + 12'd2;
  assign pc4 = pc + 12'd4;
  assign sum = {1'b0, vx} + {1'b0, vy};

  // lowest pressed key
  always_comb begin
    penc = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys[i]) penc = 4'(i);
    end
  end

  always_comb begin
    skip      = 1'b0;
    pc_exec   = pc2;
    rf_we     = 1'b0;
    rf_widx   = x;
    rf_wval   = 8'd0;
    wb2_idx_n = REG_VF;
    wb2_val_n = 8'd0;
    phase     = PH_DONE;
    unk_n     = 1'b0;
    wt_n      = 1'b0;
    case (grp)
      GRP_SYS: begin
        if (op == OP_RET) begin
          pc_exec = stk[sp - 4'd1];
        end else if (op != OP_CLS) begin
          unk_n = 1'b1;
        end
      end
      GRP_JP, GRP_CALL: pc_exec = nnn;
      GRP_SE:   skip = (vx == kk);
      GRP_SNE:  skip = (vx != kk);
      GRP_SER:  skip = (vx == vy);
      GRP_SNER: skip = (vx != vy);
      GRP_LD: begin
        rf_we   = 1'b1;
        rf_wval = kk;
      end
      GRP_ADD: begin
        rf_we   = 1'b1;
        rf_wval = vx + kk;
      end
      GRP_ALU: begin
        rf_we = 1'b1;
        case (n)
          ALU_MOV: rf_wval = vy;
          ALU_OR:  rf_wval = vx | vy;
          ALU_AND: rf_wval = vx & vy;
          ALU_XOR: rf_wval = vx ^ vy;
          ALU_ADD: begin
            rf_wval   = sum[7:0];
            wb2_val_n = {7'd0, sum[8]};
            phase     = PH_VF;
          end
          ALU_SUB: begin
            rf_widx   = REG_VF;
            rf_wval   = {7'd0, vx > vy};
            wb2_idx_n = x;
            wb2_val_n = vx - vy;
            phase     = PH_VF;
          end
          ALU_SHR: begin
            rf_widx   = REG_VF;
            rf_wval   = {7'd0, vx[0]};
            wb2_idx_n = x;
            wb2_val_n = {1'b0, vx[7:1]};
            phase     = PH_VF;
          end
          ALU_SUBN: begin
            rf_widx   = REG_VF;
            rf_wval   = {7'd0, vy > vx};
            wb2_idx_n = x;
            wb2_val_n = vy - vx;
            phase     = PH_VF;
          end
          ALU_SHL: begin
            rf_widx   = REG_VF;
            rf_wval   = {7'd0, vx[7]};
            wb2_idx_n = x;
            wb2_val_n = {vx[6:0], 1'b0};
            phase     = PH_VF;
          end
          default: begin
            rf_we = 1'b0;
            unk_n = 1'b1;
          end
        endcase
      end
      GRP_LDI: ;
      // vy holds v0 for this group
      GRP_JPV: pc_exec = nnn + {4'd0, vy};
      GRP_RND: begin
        rf_we   = 1'b1;
        rf_wval = item.random_byte & kk;
      end
      GRP_DRW: phase = (n == 4'd0) ? PH_VF : PH_DRAW;
      GRP_KEY: begin
        if (kk == KK_SKP) begin
          skip = keys[vx[3:0]];
        end else if (kk == KK_SKNP) begin
          skip = !keys[vx[3:0]];
        end else begin
          unk_n = 1'b1;
        end
      end
      default: begin
        case (kk)
          KK_GET_DT: begin
            rf_we   = 1'b1;
            rf_wval = dt;
          end
          KK_WAIT: begin
            if (keys == 16'd0) begin
              pc_exec = pc;
              wt_n    = 1'b1;
            end else begin
              rf_we   = 1'b1;
              rf_wval = {4'd0, penc};
            end
          end
          KK_SET_DT, KK_SET_ST, KK_ADD_I, KK_FONT: ;
          KK_BCD:   phase = PH_BCD;
          KK_STORE: phase = PH_STORE;
          KK_LOAD:  phase = PH_LOAD;
          default:  unk_n = 1'b1;
        endcase
      end
    endcase
    if (skip) pc_exec = pc4;
  end

  // register file read port
  always_comb begin
    case (cmd)
      CMD_RD_Y:  rf_raddr = (grp == GRP_JPV) ? 4'd0 : op[7:4];
      CMD_STORE: rf_raddr = cnt;
      default:   rf_raddr = x;
    endcase
  end
  assign rf_rdata = rf[rf_raddr];

  // memory port
  always_comb begin
    case (cmd)
      CMD_SIMPLE:   mem_addr = item.address;
      CMD_FETCH_HI: mem_addr = pc;
      CMD_FETCH_LO: mem_addr = pc + 12'd1;
      default:      mem_addr = ireg[11:0] + {8'd0, cnt};
    endcase
    mem_we = 1'b0;
    mem_wd = rf_rdata;
    case (cmd)
      CMD_SIMPLE: begin
        mem_we = (item.mode == MODE_LOAD);
        mem_wd = item.data;
      end
      CMD_BCD: begin
        mem_we = 1'b1;
        mem_wd = bcd_digit;
      end
      CMD_STORE: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rdata <= mem[mem_addr];
  end

  // sprite row: byte rotated right to column vx
  assign spr_dbl  = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> vx[5:0];
  assign spr_mask = spr_dbl[63:0];
  assign row_idx  = vy[4:0] + {1'b0, cnt};
  assign row_val  = rows[row_idx];
  assign hit_n    = hit | (|(row_val & spr_mask));

  // decimal digits of vx
  always_comb begin
    if (vx >= 8'd200) begin
      bcd_h = 2'd2;
      bcd_r = vx - 8'd200;
    end else if (vx >= 8'd100) begin
      bcd_h = 2'd1;
      bcd_r = vx - 8'd100;
    end else begin
      bcd_h = 2'd0;
      bcd_r = vx;
    end
    bcd_prod = {8'd0, bcd_r[6:0]} * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_r - {bcd_t, 3'd0} - {3'd0, bcd_t, 1'b0};
    case (cnt)
      4'd0:    bcd_digit = {6'd0, bcd_h};
      4'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = bcd_o;
    endcase
  end

  // status
  always_comb begin
    stat.is_exec = (item.mode == MODE_EXEC);
    stat.is_byte = (item.mode == MODE_BYTE);
    stat.phase   = phase;
    case (cmd)
      CMD_DRAW_ROW:          stat.last = ({1'b0, cnt} + 5'd1 == {1'b0, n});
      CMD_BCD:               stat.last = (cnt == 4'd2);
      CMD_STORE, CMD_LOAD_WR: stat.last = (cnt == x);
      default:               stat.last = 1'b0;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_RESET;
      ireg <= 16'd0;
      sp   <= 4'd0;
      dt   <= 8'd0;
      st   <= 8'd0;
      keys <= 16'd0;
      for (int i = 0; i < 16; i++) rf[i] <= 8'd0;
      for (int i = 0; i < SCREEN_H; i++) rows[i] <= 64'd0;
    end else begin
      if (cfg_write) pc <= cfg_data;
      case (cmd)
        CMD_SIMPLE: begin
          if (item.mode == MODE_TICK) begin
            if (dt != 8'd0) dt <= dt - 8'd1;
            if (st != 8'd0) st <= st - 8'd1;
          end
          if (item.mode == MODE_KEY) keys[item.key_index] <= item.key_pressed;
        end
        CMD_EXEC: begin
          pc <= pc_exec;
          if (rf_we) rf[rf_widx] <= rf_wval;
          if (op == OP_CLS) begin
            for (int i = 0; i < SCREEN_H; i++) rows[i] <= 64'd0;
          end
          if (op == OP_RET) sp <= sp - 4'd1;
          if (grp == GRP_CALL) sp <= sp + 4'd1;
          if (grp == GRP_LDI) ireg <= {4'd0, nnn};
          if (grp == GRP_MISC) begin
            if (kk == KK_SET_DT) dt <= vx;
            if (kk == KK_SET_ST) st <= vx;
            if (kk == KK_ADD_I) ireg <= ireg + {8'd0, vx};
            if (kk == KK_FONT) ireg <= {9'd0, {3'd0, vx[3:0]} * 7'd5};
          end
        end
        CMD_DRAW_ROW: rows[row_idx] <= row_val ^ spr_mask;
        CMD_LOAD_WR:  rf[cnt] <= mem_rdata;
        CMD_SETVF:    rf[wb2_idx] <= wb2_val;
        default: ;
      endcase
    end
  end

  // return stack, written by call only
  always_ff @(posedge clk) begin
    if (cmd == CMD_EXEC && grp == GRP_CALL) stk[sp] <= pc2;
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_CAPTURE: begin
        item <= in_data;
        op   <= 16'd0;
        rd   <= 64'd0;
        unk  <= 1'b0;
        wt   <= 1'b0;
      end
      CMD_SIMPLE: begin
        if (item.mode == MODE_ROW) rd <= rows[item.address[4:0]];
      end
      CMD_RDBYTE:    rd <= {56'd0, mem_rdata};
      CMD_FETCH_LO:  op[15:8] <= mem_rdata;
      CMD_FETCH_END: begin
        op[7:0] <= mem_rdata;
        vx      <= rf_rdata;
      end
      CMD_RD_Y: vy <= rf_rdata;
      CMD_EXEC: begin
        unk     <= unk_n;
        wt      <= wt_n;
        hit     <= 1'b0;
        cnt     <= 4'd0;
        wb2_idx <= wb2_idx_n;
        wb2_val <= wb2_val_n;
      end
      CMD_DRAW_ROW: begin
        hit     <= hit_n;
        wb2_val <= {7'd0, hit_n};
        cnt     <= cnt + 4'd1;
      end
      CMD_BCD, CMD_STORE, CMD_LOAD_WR: cnt <= cnt + 4'd1;
      CMD_OUT: begin
        out_data.program_counter <= pc;
        out_data.opcode_done     <= op;
        out_data.index_value     <= ireg;
        out_data.delay_value     <= dt;
        out_data.sound_on        <= (st != 8'd0);
        out_data.unknown_opcode  <= unk;
        out_data.waiting_key     <= wt;
        out_data.read_data       <= rd;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/chip8_instruction_step.sv @@
// top level of the chip-8 instruction step core
`default_nettype none
// One beat in gives one beat out. Each input beat loads a memory byte, executes one
// instruction, ticks the timers, records a key event, or reads back a display row
// or a memory byte. Beats are handled one at a time through a single-port 4096x8
// memory: an instruction fetches its two opcode bytes and reads both register
// operands before it executes, then, as it needs them, steps through sprite rows,
// BCD digits or registers to store or load, and may end with a second register
// write to VF or Vx. The result sits in an output register, so a new beat is taken
// while the previous result waits. A write on the config port loads the program
// counter (512 after reset); write it only while the core is idle. Memory and the
// return stack come up unknown until written; registers, timers, keys and the
// frame buffer come up cleared.
module chip8_instruction_step import c8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config: program start address
  input  logic        cfg_write,
  input  logic [11:0] cfg_data,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  c8_in_t      in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output c8_out_t     out_data
);

  // controller to datapath commands and back status
  c8_cmd_t  cmd;
  c8_stat_t stat;

  // sequencer: accepts a beat, steps the datapath, loads the result register
  c8_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // all machine state and the result payload
  c8_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
